FILE: hdl/max_priority_queue_array_assert.svh
// Assertion macros shared by the checker of the max priority queue.
`ifndef MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ARRAY_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mpq_pkg.sv
// Package with the sizes, codes and shared types of the max priority queue.
package mpq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ID_W     = 32;
   localparam int KEY_W    = 16;
   localparam int FUNC_W   = 2;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = ID_W + KEY_W;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan;
      logic shift;
      logic pop_commit;
      logic load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_go;
      logic scan_last;
      logic shift_done;
      logic out_free;
   } stat_type;

endpackage

FILE: hdl/mpq_if.sv
// Valid/ready channel interfaces for request and response words.
interface mpq_req_if;
   logic                            valid;
   logic                            ready;
   logic [mpq_pkg::FUNC_W-1:0]      func;
   logic [mpq_pkg::ID_W-1:0]        entry_id;
   logic signed [mpq_pkg::KEY_W-1:0] entry_key;

   modport source (output valid, func, entry_id, entry_key, input ready);
   modport sink   (input valid, func, entry_id, entry_key, output ready);
endinterface

interface mpq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mpq_pkg::STAT_W-1:0]       status;
   logic [mpq_pkg::ID_W-1:0]         removed_id;
   logic signed [mpq_pkg::KEY_W-1:0] removed_key;
   logic [mpq_pkg::COUNT_W-1:0]      count;
   logic                             head_valid;
   logic [mpq_pkg::ID_W-1:0]         head_id;
   logic signed [mpq_pkg::KEY_W-1:0] head_key;

   modport source (output valid, status, removed_id, removed_key, count, head_valid,
                   head_id, head_key, input ready);
   modport sink   (input valid, status, removed_id, removed_key, count, head_valid,
                   head_id, head_key, output ready);
endinterface

FILE: hdl/mpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mpq_ctrl.sv
// Sequencer that steps the queue through accept, scan, shift and result phases.
module mpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpq_pkg::stat_type stat,
   output mpq_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = stat.pop_go ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.pop_commit = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.load = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/mpq_datapath.sv
// Datapath: slot store, running maximum search, shift-down pass and result word.
module mpq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mpq_pkg::cmd_type                 cmd,
   output mpq_pkg::stat_type                stat,
   input  logic [mpq_pkg::FUNC_W-1:0]       req_func,
   input  logic [mpq_pkg::ID_W-1:0]         req_entry_id,
   input  logic signed [mpq_pkg::KEY_W-1:0] req_entry_key,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [mpq_pkg::STAT_W-1:0]       rsp_status,
   output logic [mpq_pkg::ID_W-1:0]         rsp_removed_id,
   output logic signed [mpq_pkg::KEY_W-1:0] rsp_removed_key,
   output logic [mpq_pkg::COUNT_W-1:0]      rsp_count,
   output logic                             rsp_head_valid,
   output logic [mpq_pkg::ID_W-1:0]         rsp_head_id,
   output logic signed [mpq_pkg::KEY_W-1:0] rsp_head_key
);

   localparam int IDX_W = mpq_pkg::IDX_W;
   localparam int CNT_W = mpq_pkg::CNT_W;

   // Queue state.
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  head_valid_ff, head_valid_in;
   mpq_pkg::slot_type     head_ff, head_in;

   // Per-operation result.
   logic [mpq_pkg::STAT_W-1:0] status_ff, status_in;
   mpq_pkg::slot_type          removed_ff, removed_in;

   // Read pipeline and search state.
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              dv_ff;
   logic [IDX_W-1:0]  dpos_ff;
   mpq_pkg::slot_type best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   mpq_pkg::slot_type run_ff, run_in;
   logic              run_valid_ff, run_valid_in;

   // Output register.
   logic                       rsp_valid_ff;
   logic [mpq_pkg::STAT_W-1:0] rsp_status_ff;
   mpq_pkg::slot_type          rsp_removed_ff;
   logic [mpq_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                       rsp_head_valid_ff;
   mpq_pkg::slot_type          rsp_head_ff;

   // RAM port signals.
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   mpq_pkg::slot_type wr_data;
   mpq_pkg::slot_type rd_data;

   logic              full;
   logic              issue_en;
   logic [CNT_W-1:0]  fill_last;
   logic              is_push;
   logic              is_pop;

   assign full      = (fill_ff == CNT_W'(mpq_pkg::CAPACITY));
   assign fill_last = fill_ff - 1'b1;
   assign is_push   = (req_func == mpq_pkg::FUNC_PUSH);
   assign is_pop    = (req_func == mpq_pkg::FUNC_POP);
   assign issue_en  = (cmd.scan || cmd.shift) && (rd_cnt_ff < fill_ff);

   assign stat.pop_go     = is_pop && (fill_ff != '0);
   assign stat.scan_last  = cmd.scan && dv_ff && (CNT_W'(dpos_ff) == fill_last);
   assign stat.shift_done = cmd.shift && (rd_cnt_ff == fill_ff) && !dv_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   mpq_ram #(
      .WIDTH (mpq_pkg::SLOT_W),
      .DEPTH (mpq_pkg::CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // A push appends at the fill position; the shift pass moves each word after the maximum one slot down.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[IDX_W-1:0];
      wr_data = '{id: req_entry_id, key: req_entry_key};
      if (cmd.accept && is_push && !full) begin
         wr_en = 1'b1;
      end else if (cmd.shift && dv_ff) begin
         wr_en   = 1'b1;
         wr_addr = dpos_ff - 1'b1;
         wr_data = rd_data;
      end
   end

   // Scan keeps the maximum and the runner-up; the runner-up becomes the head after a pop.
   // Strict compares keep the earliest entry among equal keys.
   always_comb begin
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      if (cmd.scan && dv_ff) begin
         if (dpos_ff == '0) begin
            best_in      = rd_data;
            best_idx_in  = '0;
            run_valid_in = 1'b0;
         end else if ($signed(rd_data.key) > $signed(best_ff.key)) begin
            run_in       = best_ff;
            run_valid_in = 1'b1;
            best_in      = rd_data;
            best_idx_in  = dpos_ff;
         end else if (!run_valid_ff || ($signed(rd_data.key) > $signed(run_ff.key))) begin
            run_in       = rd_data;
            run_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      priority if (cmd.accept) begin
         rd_cnt_in = '0;
      end else if (stat.scan_last) begin
         rd_cnt_in = CNT_W'(best_idx_in) + 1'b1;
      end else if (issue_en) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;
      if (cmd.accept) begin
         status_in  = mpq_pkg::STAT_OK;
         removed_in = '0;
         if (is_push) begin
            if (full) begin
               status_in = mpq_pkg::STAT_FULL;
            end else begin
               fill_in = fill_ff + 1'b1;
               if (!head_valid_ff || (req_entry_key > $signed(head_ff.key))) begin
                  head_valid_in = 1'b1;
                  head_in       = '{id: req_entry_id, key: req_entry_key};
               end
            end
         end else if (is_pop && (fill_ff == '0)) begin
            status_in = mpq_pkg::STAT_EMPTY;
         end
      end else if (cmd.pop_commit) begin
         fill_in       = fill_last;
         removed_in    = best_ff;
         head_valid_in = run_valid_ff;
         head_in       = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         head_valid_ff <= 1'b0;
         dv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         head_valid_ff <= head_valid_in;
         dv_ff         <= issue_en;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      rd_cnt_ff    <= rd_cnt_in;
      dpos_ff      <= rd_cnt_ff[IDX_W-1:0];
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      run_ff       <= run_in;
      run_valid_ff <= run_valid_in;
      if (cmd.load) begin
         rsp_status_ff     <= status_ff;
         rsp_removed_ff    <= removed_ff;
         rsp_count_ff      <= mpq_pkg::COUNT_W'(fill_ff);
         rsp_head_valid_ff <= head_valid_ff;
         rsp_head_ff       <= head_valid_ff ? head_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_removed_id  = rsp_removed_ff.id;
   assign rsp_removed_key = rsp_removed_ff.key;
   assign rsp_count       = rsp_count_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_id     = rsp_head_ff.id;
   assign rsp_head_key    = rsp_head_ff.key;

endmodule

FILE: hdl/max_priority_queue_array.sv
// Push, peek and refused operations go from acceptance straight to loading their result word.
// A pop makes two passes of RAM reads: one finds the maximum, and a second shifts the later
// slots down one a cycle.
// One word is handled at a time; the next request is taken the cycle after the result loads.
// Reset (synchronous, active high) empties the queue and drops any pending result word;
// the slot RAM is not cleared.
module max_priority_queue_array (
   input  logic      clock,
   input  logic      reset,
   mpq_req_if.sink   req_ch,
   mpq_rsp_if.source rsp_ch
);

   mpq_pkg::cmd_type  cmd;
   mpq_pkg::stat_type stat;
   logic              req_ready;

   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_ch.func),
      .req_entry_id    (req_ch.entry_id),
      .req_entry_key   (req_ch.entry_key),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_removed_id  (rsp_ch.removed_id),
      .rsp_removed_key (rsp_ch.removed_key),
      .rsp_count       (rsp_ch.count),
      .rsp_head_valid  (rsp_ch.head_valid),
      .rsp_head_id     (rsp_ch.head_id),
      .rsp_head_key    (rsp_ch.head_key)
   );

   assign req_ch.ready = req_ready;

endmodule

FILE: hdl/mpq_checker.sv
// Port-level checker for the max priority queue, bound to the top level.
`include "max_priority_queue_array_assert.svh"

module mpq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mpq_pkg::STAT_W-1:0]       status,
   input logic [mpq_pkg::ID_W-1:0]         removed_id,
   input logic signed [mpq_pkg::KEY_W-1:0] removed_key,
   input logic [mpq_pkg::COUNT_W-1:0]      count,
   input logic                             head_valid,
   input logic [mpq_pkg::ID_W-1:0]         head_id,
   input logic signed [mpq_pkg::KEY_W-1:0] head_key
);

   `MPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(count), "stalled response word changed")

   `MPQ_ASSERT_IMPLY(a_empty_head, rsp_valid && !head_valid, count == '0 && head_id == '0 && head_key == '0, "empty queue must report zero head and count")

   `MPQ_ASSERT_IMPLY(a_pop_empty, rsp_valid && status == mpq_pkg::STAT_EMPTY, count == '0 && !head_valid && removed_id == '0 && removed_key == '0, "pop on empty reported wrong fields")

   `MPQ_ASSERT_IMPLY(a_push_full, rsp_valid && status == mpq_pkg::STAT_FULL, count == mpq_pkg::COUNT_W'(mpq_pkg::CAPACITY) && head_valid && removed_id == '0, "refused push without a full queue")

endmodule

bind max_priority_queue_array mpq_checker u_mpq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .status      (rsp_ch.status),
   .removed_id  (rsp_ch.removed_id),
   .removed_key (rsp_ch.removed_key),
   .count       (rsp_ch.count),
   .head_valid  (rsp_ch.head_valid),
   .head_id     (rsp_ch.head_id),
   .head_key    (rsp_ch.head_key)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the unsorted-array max priority queue.
module testbench;

   // A selector of three is treated by the block as a peek.
   localparam logic [mpq_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int RANDOM_WORDS = 1450;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 150;

   typedef struct {
      logic [mpq_pkg::STAT_W-1:0]  status;
      logic [mpq_pkg::ID_W-1:0]    removed_id;
      logic [mpq_pkg::KEY_W-1:0]   removed_key;
      logic [mpq_pkg::COUNT_W-1:0] count;
      logic                        head_valid;
      logic [mpq_pkg::ID_W-1:0]    head_id;
      logic [mpq_pkg::KEY_W-1:0]   head_key;
   } pq_result_type;

   typedef struct {
      logic [mpq_pkg::FUNC_W-1:0] func;
      logic [mpq_pkg::ID_W-1:0]   id;
      logic [mpq_pkg::KEY_W-1:0]  key;
      bit                         known;
      pq_result_type              word;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpq_req_if req_ch ();
   mpq_rsp_if rsp_ch ();

   max_priority_queue_array dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the queue contents, in insertion order.
   mpq_pkg::slot_type shadow_slots [mpq_pkg::CAPACITY];
   int                shadow_fill = 0;
   pq_result_type     expected_words [$];
   pq_result_type     no_word;
   int                mismatches = 0;
   int                words_sent = 0;
   bit                calm = 1'b0;
   bit                pressure_done = 1'b0;

   // Rows with a filled-in word are checked against that word; the rest use the shadow queue.
   plan_row_type directed_plan [25] = '{
      '{mpq_pkg::FUNC_POP,  32'h0,        16'h0,    1'b1,
        '{mpq_pkg::STAT_EMPTY, 0, 0, 0, 0, 0, 0}},
      '{mpq_pkg::FUNC_PEEK, 32'h0,        16'h0,    1'b1,
        '{mpq_pkg::STAT_OK, 0, 0, 0, 0, 0, 0}},
      '{FUNC_SPARE,         32'hFFFFFFFF, 16'hFFFF, 1'b1,
        '{mpq_pkg::STAT_OK, 0, 0, 0, 0, 0, 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h0,        16'h8000, 1'b1,
        '{mpq_pkg::STAT_OK, 0, 0, 1, 1, 0, 16'h8000}},
      '{mpq_pkg::FUNC_PUSH, 32'hFFFFFFFF, 16'h7FFF, 1'b1,
        '{mpq_pkg::STAT_OK, 0, 0, 2, 1, 32'hFFFFFFFF, 16'h7FFF}},
      '{mpq_pkg::FUNC_PUSH, 32'h1,        16'h7FFF, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h2,        16'hFFFF, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h3,        16'h0000, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h4,        16'h0001, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h5,        16'h7FFE, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h6,        16'h8001, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h7,        16'h0000, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h8,        16'h7FFF, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h9,        16'h8000, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'hA5A5A5A5, 16'h5A5A, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h5A5A5A5A, 16'hA5A5, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'hFFFFFFFE, 16'h7FFF, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h80000000, 16'h1234, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h7FFFFFFF, 16'h8000, 1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PUSH, 32'h12345678, 16'h7FFF, 1'b1,
        '{mpq_pkg::STAT_FULL, 0, 0, 16, 1, 32'hFFFFFFFF, 16'h7FFF}},
      '{mpq_pkg::FUNC_POP,  32'h0,        16'h0,    1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_POP,  32'h0,        16'h0,    1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_PEEK, 32'h0,        16'h0,    1'b0, '{default: 0}},
      '{FUNC_SPARE,         32'h0,        16'h0,    1'b0, '{default: 0}},
      '{mpq_pkg::FUNC_POP,  32'h0,        16'h0,    1'b0, '{default: 0}}
   };

   initial begin
      forever #2 clock = ~clock;
   end

   // Slot of the greatest signed key among held entries; the earliest wins a tie.
   function automatic int best_slot();
      int best;
      best = 0;
      for (int i = 1; i < shadow_fill; i++)
         if ($signed(shadow_slots[i].key) > $signed(shadow_slots[best].key))
            best = i;
      return best;
   endfunction

   function automatic pq_result_type apply_to_shadow(
         input logic [mpq_pkg::FUNC_W-1:0] func,
         input logic [mpq_pkg::ID_W-1:0] id,
         input logic [mpq_pkg::KEY_W-1:0] key);
      pq_result_type outcome;
      int m;
      outcome = '{default: 0};
      outcome.status = mpq_pkg::STAT_OK;
      if (func == mpq_pkg::FUNC_PUSH) begin
         if (shadow_fill >= mpq_pkg::CAPACITY) begin
            outcome.status = mpq_pkg::STAT_FULL;
         end else begin
            shadow_slots[shadow_fill].id = id;
            shadow_slots[shadow_fill].key = key;
            shadow_fill++;
         end
      end else if (func == mpq_pkg::FUNC_POP) begin
         if (shadow_fill == 0) begin
            outcome.status = mpq_pkg::STAT_EMPTY;
         end else begin
            m = best_slot();
            outcome.removed_id = shadow_slots[m].id;
            outcome.removed_key = shadow_slots[m].key;
            for (int i = m; i + 1 < shadow_fill; i++)
               shadow_slots[i] = shadow_slots[i + 1];
            shadow_fill--;
         end
      end
      outcome.count = shadow_fill[mpq_pkg::COUNT_W-1:0];
      if (shadow_fill > 0) begin
         m = best_slot();
         outcome.head_valid = 1'b1;
         outcome.head_id = shadow_slots[m].id;
         outcome.head_key = shadow_slots[m].key;
      end
      return outcome;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatches < 100)
         $display("mismatch in %s: got %0h, want %0h", what, got, want);
      mismatches++;
   endtask

   task automatic check_word(input pq_result_type want);
      if (rsp_ch.status !== want.status)
         flag_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
      if (rsp_ch.removed_id !== want.removed_id)
         flag_mismatch("removed_id", 64'(rsp_ch.removed_id), 64'(want.removed_id));
      if (rsp_ch.removed_key !== want.removed_key)
         flag_mismatch("removed_key", 64'(rsp_ch.removed_key), 64'(want.removed_key));
      if (rsp_ch.count !== want.count)
         flag_mismatch("count", 64'(rsp_ch.count), 64'(want.count));
      if (rsp_ch.head_valid !== want.head_valid)
         flag_mismatch("head_valid", 64'(rsp_ch.head_valid), 64'(want.head_valid));
      if (rsp_ch.head_id !== want.head_id)
         flag_mismatch("head_id", 64'(rsp_ch.head_id), 64'(want.head_id));
      if (rsp_ch.head_key !== want.head_key)
         flag_mismatch("head_key", 64'(rsp_ch.head_key), 64'(want.head_key));
   endtask

   // Offers one word starting at a falling edge and returns at the falling edge after it is taken.
   task automatic offer_word(input logic [mpq_pkg::FUNC_W-1:0] func,
                             input logic [mpq_pkg::ID_W-1:0] id,
                             input logic [mpq_pkg::KEY_W-1:0] key, input bit known,
                             input pq_result_type typed);
      pq_result_type outcome;
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.entry_id <= id;
      req_ch.entry_key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outcome = apply_to_shadow(func, id, key);
      expected_words.push_back(known ? typed : outcome);
      words_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0)
            flag_mismatch("result word with nothing expected", 64'(rsp_ch.status), 64'h0);
         else
            check_word(expected_words.pop_front());
      end
   end

   // The receiver stalls at random, and once holds off long enough for the block to back up.
   initial begin : receiver
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!pressure_done && words_sent >= 400) begin
            pressure_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= calm || $urandom_range(0, 99) >= 29;
         end
      end
   end

   initial begin : stimulus
      int n;
      int pick;
      int push_pct;
      logic [mpq_pkg::FUNC_W-1:0] func;
      logic [mpq_pkg::KEY_W-1:0]  key;
      req_ch.valid = 1'b0;
      req_ch.func = mpq_pkg::FUNC_PEEK;
      req_ch.entry_id = '0;
      req_ch.entry_key = '0;
      no_word = '{default: 0};
      push_pct = 50;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         offer_word(directed_plan[i].func, directed_plan[i].id, directed_plan[i].key,
                    directed_plan[i].known, directed_plan[i].word);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         // Phases favour pushes, pops or neither, so the queue swings between full and empty.
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  push_pct = 85;
               end
               1: begin
                  push_pct = 50;
               end
               default: begin
                  push_pct = 15;
               end
            endcase
         end
         calm = (n >= 600 && n < 900);
         pick = $urandom_range(0, 99);
         if (pick < 4)
            func = FUNC_SPARE;
         else if (pick < 12)
            func = mpq_pkg::FUNC_PEEK;
         else if (pick - 12 < push_pct * 88 / 100)
            func = mpq_pkg::FUNC_PUSH;
         else
            func = mpq_pkg::FUNC_POP;
         // Narrow keys make ties common; the rest hit the extremes or the full range.
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            key = mpq_pkg::KEY_W'($urandom_range(0, 6) - 3);
         end else if (pick < 35) begin
            case ($urandom_range(0, 3))
               0: key = 16'h8000;
               1: key = 16'h8001;
               2: key = 16'h7FFE;
               default: key = 16'h7FFF;
            endcase
         end else begin
            key = mpq_pkg::KEY_W'($urandom);
         end
         offer_word(func, mpq_pkg::ID_W'($urandom), key, 1'b0, no_word);
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("max_priority_queue_array test passed");
      else
         $display("max_priority_queue_array test failed");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("max_priority_queue_array test failed");
      $finish;
   end

endmodule
